FILE: hw/rtl/ngds_pkg.sv
// ----------------------------------------------------------------------------
// ngds_pkg
// Shared constants, codes and types of the neighbor gate and distance sort.
// ----------------------------------------------------------------------------
`default_nettype none

package ngds_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int QUEUE_DEPTH  = 4;
    localparam int POS_W        = 24;
    localparam int VEL_W        = 16;
    localparam int SPC_W        = 32;
    localparam int KEY_W        = 32;
    localparam int RAD_W        = 16;
    localparam int CFG_IDX_W    = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_NEIGHBOR_RADIUS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEPARATION_RADIUS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AVOID_ONLY_RADIUS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_RADIUS      = 2'd3;

    // Item classes handed from the front end to the sorter.
    localparam logic [1:0] CLS_ORIGIN = 2'd0;
    localparam logic [1:0] CLS_KEEP   = 2'd1;
    localparam logic [1:0] CLS_DROP   = 2'd2;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] depth;
        logic signed [VEL_W-1:0] vx;
        logic signed [VEL_W-1:0] vy;
        logic [SPC_W-1:0]        species;
        logic                    avoid;
    } t_nbr;

    typedef struct packed {
        logic [1:0]       cls;
        logic             eol;
        t_nbr             nbr;
        logic [KEY_W-1:0] key;
    } t_item;

    typedef struct packed {
        t_nbr             nbr;
        logic [KEY_W-1:0] key;
    } t_slot;

    typedef struct packed {
        t_nbr             nbr;
        logic [KEY_W-1:0] key;
        logic             last;
        logic             empty_list;
        logic             dropped;
    } t_result;

endpackage

`default_nettype wire

FILE: hw/rtl/ngds_front.sv
// ----------------------------------------------------------------------------
// ngds_front
// Accepts items, holds the radii and the own position, and classifies each
// neighbor through a two-stage gate pipeline (differences, then squares).
// ----------------------------------------------------------------------------
`default_nettype none

module ngds_front (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire logic [ngds_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [ngds_pkg::RAD_W-1:0]           i_cfg_data,
    input  wire logic                                 i_push,
    output logic                                      o_full,
    input  wire logic                                 i_command,
    input  wire logic                                 i_end_of_list,
    input  wire ngds_pkg::t_nbr                       i_nbr,
    output logic                                      o_q_wr,
    output ngds_pkg::t_item                           o_q_item,
    input  wire logic                                 i_q_full
);

    localparam int PW = ngds_pkg::POS_W;
    localparam int RW = ngds_pkg::RAD_W;
    localparam int KW = ngds_pkg::KEY_W;

    logic [RW-1:0] r_nbr_rad, r_sep_rad, r_avd_rad, r_dep_rad;
    logic signed [PW-1:0] r_own_x, r_own_y, r_own_d;

    logic en, accept;

    logic signed [PW:0] dxs, dys, dds;
    logic [PW:0]        dx_abs, dy_abs, dd_abs;
    logic [RW-1:0]      rmax_ab, rmax;
    logic               gate1;

    logic               r_v1, r_cmd1, r_cand1, r_eol1;
    ngds_pkg::t_nbr     r_nbr1;
    logic [RW-1:0]      r_dx1, r_dy1, r_rmax1;

    logic               r_v2, r_cmd2, r_cand2, r_eol2;
    ngds_pkg::t_nbr     r_nbr2;
    logic [KW-1:0]      r_sqx2, r_sqy2, r_lim2;

    logic [KW-1:0]      sqx, sqy, lim;
    logic [KW:0]        sum;
    logic               keep;

    assign en     = !i_q_full;
    assign o_full = i_q_full;
    assign accept = i_push && en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nbr_rad <= '0;
            r_sep_rad <= '0;
            r_avd_rad <= '0;
            r_dep_rad <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ngds_pkg::CFG_NEIGHBOR_RADIUS:   r_nbr_rad <= i_cfg_data;
                ngds_pkg::CFG_SEPARATION_RADIUS: r_sep_rad <= i_cfg_data;
                ngds_pkg::CFG_AVOID_ONLY_RADIUS: r_avd_rad <= i_cfg_data;
                ngds_pkg::CFG_DEPTH_RADIUS:      r_dep_rad <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_x <= '0;
            r_own_y <= '0;
            r_own_d <= '0;
        end else if (accept && !i_command) begin
            r_own_x <= i_nbr.x;
            r_own_y <= i_nbr.y;
            r_own_d <= i_nbr.depth;
        end
    end

    // Stage 1: absolute differences and the depth gate.
    always_comb begin
        dxs    = {i_nbr.x[PW-1], i_nbr.x} - {r_own_x[PW-1], r_own_x};
        dys    = {i_nbr.y[PW-1], i_nbr.y} - {r_own_y[PW-1], r_own_y};
        dds    = {i_nbr.depth[PW-1], i_nbr.depth} - {r_own_d[PW-1], r_own_d};
        dx_abs = dxs[PW] ? (PW+1)'(-dxs) : (PW+1)'(dxs);
        dy_abs = dys[PW] ? (PW+1)'(-dys) : (PW+1)'(dys);
        dd_abs = dds[PW] ? (PW+1)'(-dds) : (PW+1)'(dds);
        rmax_ab = (r_sep_rad > r_nbr_rad) ? r_sep_rad : r_nbr_rad;
        rmax    = (r_avd_rad > rmax_ab) ? r_avd_rad : rmax_ab;
        // An offset beyond the radius range can never fall inside the limit.
        gate1 = (dd_abs <= (PW+1)'(r_dep_rad))
             && (dx_abs[PW:RW] == '0) && (dy_abs[PW:RW] == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v1 <= accept;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cmd1  <= i_command;
            r_cand1 <= gate1;
            r_eol1  <= i_end_of_list;
            r_nbr1  <= i_nbr;
            r_dx1   <= dx_abs[RW-1:0];
            r_dy1   <= dy_abs[RW-1:0];
            r_rmax1 <= rmax;

            r_cmd2  <= r_cmd1;
            r_cand2 <= r_cand1;
            r_eol2  <= r_eol1;
            r_nbr2  <= r_nbr1;
            r_sqx2  <= sqx;
            r_sqy2  <= sqy;
            r_lim2  <= lim;
        end
    end

    // Stage 2: squares of the offsets and of the largest radius.
    assign sqx = KW'(r_dx1) * KW'(r_dx1);
    assign sqy = KW'(r_dy1) * KW'(r_dy1);
    assign lim = KW'(r_rmax1) * KW'(r_rmax1);

    // Distance gate, then the item goes into the queue.
    always_comb begin
        sum  = {1'b0, r_sqx2} + {1'b0, r_sqy2};
        keep = r_cand2 && (sum != '0) && (sum <= {1'b0, r_lim2});
        o_q_item.eol = r_eol2;
        o_q_item.nbr = r_nbr2;
        o_q_item.key = sum[KW-1:0];
        if (!r_cmd2) begin
            o_q_item.cls = ngds_pkg::CLS_ORIGIN;
        end else if (keep) begin
            o_q_item.cls = ngds_pkg::CLS_KEEP;
        end else begin
            o_q_item.cls = ngds_pkg::CLS_DROP;
        end
    end

    assign o_q_wr = r_v2 && en;

endmodule

`default_nettype wire

FILE: hw/rtl/ngds_queue.sv
// ----------------------------------------------------------------------------
// ngds_queue
// Short first-in first-out queue of classified items between the front end
// and the sorter.
// ----------------------------------------------------------------------------
`default_nettype none

module ngds_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_wr,
    input  wire ngds_pkg::t_item i_item,
    output logic                 o_full,
    output logic                 o_valid,
    input  wire logic            i_rd,
    output ngds_pkg::t_item      o_item
);

    localparam int DEPTH = ngds_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);

    ngds_pkg::t_item   r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wp, r_rp;
    logic [PTR_W:0]    r_cnt;
    logic              do_wr, do_rd;

    assign o_full  = (r_cnt == (PTR_W+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_wr) begin
                r_wp <= r_wp + PTR_W'(1);
            end
            if (do_rd) begin
                r_rp <= r_rp + PTR_W'(1);
            end
            if (do_wr && !do_rd) begin
                r_cnt <= r_cnt + (PTR_W+1)'(1);
            end else if (do_rd && !do_wr) begin
                r_cnt <= r_cnt - (PTR_W+1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/ngds_back.sv
// ----------------------------------------------------------------------------
// ngds_back
// Sorted neighbor store built as a shift-insert chain of cells. Each kept
// neighbor is placed in sorted order as it is taken; on end of list the chain
// shifts the sorted run out, nearest first.
// ----------------------------------------------------------------------------
`default_nettype none

module ngds_back #(
    parameter int CAPACITY = ngds_pkg::CAPACITY_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_q_valid,
    output logic                 o_q_rd,
    input  wire ngds_pkg::t_item i_q_item,
    output logic                 o_empty,
    input  wire logic            i_pop,
    output ngds_pkg::t_result    o_res
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic ST_RUN  = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic             r_state;
    ngds_pkg::t_slot  r_slot [CAPACITY];
    logic [CW-1:0]    r_count;
    logic             r_ovf;

    ngds_pkg::t_slot  new_slot;
    logic [CAPACITY-1:0] gt;
    logic             take, ins, do_pop, store_full;

    assign take       = (r_state == ST_RUN) && i_q_valid;
    assign o_q_rd     = take;
    assign ins        = take && (i_q_item.cls == ngds_pkg::CLS_KEEP);
    assign do_pop     = (r_state == ST_EMIT) && i_pop;
    assign store_full = (r_count == CW'(CAPACITY));
    assign new_slot.nbr = i_q_item.nbr;
    assign new_slot.key = i_q_item.key;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        ngds_pkg::t_slot w_prev, w_next;
        logic            w_gt_prev;

        assign gt[i] = (r_count > CW'(i)) && (r_slot[i].key > i_q_item.key);

        if (i == 0) begin : g_head
            assign w_prev    = new_slot;
            assign w_gt_prev = 1'b0;
        end else begin : g_body
            assign w_prev    = r_slot[i-1];
            assign w_gt_prev = gt[i-1];
        end

        if (i == CAPACITY - 1) begin : g_tail
            assign w_next = r_slot[i];
        end else begin : g_link
            assign w_next = r_slot[i+1];
        end

        // Farther entries move up one place; the first farther one takes the
        // new neighbor. The cell just past the run takes the last entry when
        // the run shifts, and the new neighbor when nothing is farther.
        always_ff @(posedge i_clk) begin
            if (ins && gt[i]) begin
                r_slot[i] <= w_gt_prev ? w_prev : new_slot;
            end else if (ins && (r_count == CW'(i))) begin
                r_slot[i] <= w_gt_prev ? w_prev : new_slot;
            end else if (do_pop) begin
                r_slot[i] <= w_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            unique case (r_state)
                ST_RUN: begin
                    if (take) begin
                        case (i_q_item.cls)
                            ngds_pkg::CLS_ORIGIN: begin
                                r_count <= '0;
                                r_ovf   <= 1'b0;
                            end
                            ngds_pkg::CLS_KEEP: begin
                                if (store_full) begin
                                    r_ovf <= 1'b1;
                                end else begin
                                    r_count <= r_count + CW'(1);
                                end
                            end
                            default: ;
                        endcase
                        if (i_q_item.eol) begin
                            r_state <= ST_EMIT;
                        end
                    end
                end
                ST_EMIT: begin
                    if (i_pop) begin
                        if (r_count <= CW'(1)) begin
                            r_count <= '0;
                            r_ovf   <= 1'b0;
                            r_state <= ST_RUN;
                        end else begin
                            r_count <= r_count - CW'(1);
                        end
                    end
                end
                default: r_state <= ST_RUN;
            endcase
        end
    end

    // The head cell is the nearest waiting neighbor; an empty run shows zeros.
    always_comb begin
        o_empty = (r_state != ST_EMIT);
        if (r_count != '0) begin
            o_res.nbr = r_slot[0].nbr;
            o_res.key = r_slot[0].key;
        end else begin
            o_res.nbr = '0;
            o_res.key = '0;
        end
        o_res.last       = (r_count <= CW'(1));
        o_res.empty_list = (r_count == '0);
        o_res.dropped    = r_ovf && (r_count != '0);
    end

endmodule

`default_nettype wire

FILE: hw/rtl/neighbor_gate_and_distance_sort_top.sv
// A neighbor passes the stage 1 and stage 2 registers and the queue on its way
// to the sorter; a run's results show once the sorter has taken the end-of-list
// item. Throughput: one item per cycle at the input while full is low, set by
// the two-stage gate pipeline and the shift-insert chain; one result per cycle
// out. While a run is read out the sorter takes no item; the queue absorbs up
// to four and then raises full. Reset clears radii, own position and the store.
// ----------------------------------------------------------------------------
// neighbor_gate_and_distance_sort_top
// Radius-gated nearest-neighbor sort: a gate front end, a short queue and a
// sorted shift-insert store that reads out each snapshot nearest first.
// ----------------------------------------------------------------------------
`default_nettype none

module neighbor_gate_and_distance_sort_top #(
    parameter int CAPACITY = ngds_pkg::CAPACITY_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire logic [ngds_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [ngds_pkg::RAD_W-1:0]           i_cfg_data,
    input  wire logic                                 push,
    output logic                                      full,
    input  wire logic                                 i_command,
    input  wire logic                                 i_end_of_list,
    input  wire logic signed [ngds_pkg::POS_W-1:0]    i_x_pos,
    input  wire logic signed [ngds_pkg::POS_W-1:0]    i_y_pos,
    input  wire logic signed [ngds_pkg::POS_W-1:0]    i_plane_depth,
    input  wire logic signed [ngds_pkg::VEL_W-1:0]    i_x_vel,
    input  wire logic signed [ngds_pkg::VEL_W-1:0]    i_y_vel,
    input  wire logic [ngds_pkg::SPC_W-1:0]           i_species_key,
    input  wire logic                                 i_avoid_flag,
    output logic                                      empty,
    input  wire logic                                 pop,
    output logic signed [ngds_pkg::POS_W-1:0]         o_near_x,
    output logic signed [ngds_pkg::POS_W-1:0]         o_near_y,
    output logic signed [ngds_pkg::POS_W-1:0]         o_near_depth,
    output logic signed [ngds_pkg::VEL_W-1:0]         o_near_vx,
    output logic signed [ngds_pkg::VEL_W-1:0]         o_near_vy,
    output logic [ngds_pkg::SPC_W-1:0]                o_near_species,
    output logic                                      o_near_avoid,
    output logic [ngds_pkg::KEY_W-1:0]                o_dist_squared,
    output logic                                      o_last_result,
    output logic                                      o_empty_list,
    output logic                                      o_dropped_some
);

    ngds_pkg::t_nbr    in_nbr;
    ngds_pkg::t_item   fq_item, qb_item;
    ngds_pkg::t_result res;
    logic              fq_wr, q_full, q_valid, q_rd;

    assign in_nbr.x       = i_x_pos;
    assign in_nbr.y       = i_y_pos;
    assign in_nbr.depth   = i_plane_depth;
    assign in_nbr.vx      = i_x_vel;
    assign in_nbr.vy      = i_y_vel;
    assign in_nbr.species = i_species_key;
    assign in_nbr.avoid   = i_avoid_flag;

    ngds_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_push        (push),
        .o_full        (full),
        .i_command     (i_command),
        .i_end_of_list (i_end_of_list),
        .i_nbr         (in_nbr),
        .o_q_wr        (fq_wr),
        .o_q_item      (fq_item),
        .i_q_full      (q_full)
    );

    ngds_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (fq_wr),
        .i_item  (fq_item),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_rd    (q_rd),
        .o_item  (qb_item)
    );

    ngds_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .o_q_rd    (q_rd),
        .i_q_item  (qb_item),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_res     (res)
    );

    assign o_near_x       = res.nbr.x;
    assign o_near_y       = res.nbr.y;
    assign o_near_depth   = res.nbr.depth;
    assign o_near_vx      = res.nbr.vx;
    assign o_near_vy      = res.nbr.vy;
    assign o_near_species = res.nbr.species;
    assign o_near_avoid   = res.nbr.avoid;
    assign o_dist_squared = res.key;
    assign o_last_result  = res.last;
    assign o_empty_list   = res.empty_list;
    assign o_dropped_some = res.dropped;

endmodule

`default_nettype wire

FILE: hw/rtl/ngds_checker.sv
// ----------------------------------------------------------------------------
// ngds_checker
// Port-level checks of the result stream of the neighbor sort, bound to the
// top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ngds_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          empty,
    input wire logic                          pop,
    input wire logic [ngds_pkg::KEY_W-1:0]    o_dist_squared,
    input wire logic                          o_last_result,
    input wire logic                          o_empty_list,
    input wire logic                          o_dropped_some
);

    // Nothing waits to be read right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result shown right after reset");

    // An empty run is a single zero result that closes the run.
    a_empty_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_empty_list) |-> o_last_result)
        else $error("empty-run result not marked last");

    a_empty_run_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_empty_list) |-> (o_dist_squared == '0 && !o_dropped_some))
        else $error("empty-run result carries data");

    // Within a run the results come nearest first, with no gap.
    a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && !o_last_result) |=>
            (!empty && o_dist_squared >= $past(o_dist_squared)))
        else $error("results of a run out of distance order");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_dist_squared)))
        else $error("waiting result changed before its transfer");

endmodule

bind neighbor_gate_and_distance_sort_top ngds_checker u_ngds_checker (.*);

`default_nettype wire
